// File: design/plts_pkg.sv
// Shared constants and types for the pair link table store.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package plts_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int LINK_WIDTH_DEF = 16;

  localparam int OP_W  = 3;
  localparam int IDX_W = 16;
  localparam int VAL_W = 16;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_CHECK,
    S_SCAN,
    S_FINISH,
    S_ERROR
  } state_t;

endpackage

`default_nettype wire

// File: design/plts_in_if.sv
// Request channel of the pair link table store: valid/ready plus request fields.
// Depends on plts_pkg for field widths.
`default_nettype none

interface plts_in_if;
  logic                        valid;
  logic                        ready;
  logic [plts_pkg::OP_W-1:0]   operation;
  logic [plts_pkg::IDX_W-1:0]  entry_index;
  logic [plts_pkg::VAL_W-1:0]  source_value;
  logic [plts_pkg::VAL_W-1:0]  target_value;
  logic [plts_pkg::CNT_W-1:0]  max_matches;

  modport source (
    output valid, operation, entry_index, source_value, target_value, max_matches,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, source_value, target_value, max_matches,
    output ready
  );
endinterface

`default_nettype wire

// File: design/plts_out_if.sv
// Result channel of the pair link table store: valid/ready plus result fields.
// Depends on plts_pkg for field widths.
`default_nettype none

interface plts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [plts_pkg::IDX_W-1:0]  result_index;
  logic [plts_pkg::VAL_W-1:0]  source_out;
  logic [plts_pkg::VAL_W-1:0]  target_out;
  logic [plts_pkg::CNT_W-1:0]  match_count;
  logic                        last;

  modport source (
    output valid, status, result_index, source_out, target_out, match_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, result_index, source_out, target_out, match_count, last,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pair_link_table_store.sv
// Pair link table store: sequencer, pair memory and result register.
// Depends on plts_pkg, plts_in_if and plts_out_if.
//
// Usage:
//   in_ch takes one request beat (create, read, update, delete, count, search)
//   when valid and ready are both high; ready is high only while the sequencer
//   is idle. out_ch gives one result beat per request, or for a search one beat
//   per match (one beat if none), the final one flagged by last. cfg_we/cfg_wdata
//   set the usable capacity at any edge while the block is idle.
//   The single read port of the pair memory sets the pace: one entry is
//   examined per cycle while no search match waits on a stalled out_ch.
//   The result sits in an output register, so the next request is taken
//   while the last result of the previous one still waits.
//   When a result beat cannot go out because out_ch is stalled, the sequencer
//   holds its place and re-reads the current entry; nothing is dropped.
//   Reset empties the table (used_count 0) and sets capacity to 64; the
//   memory itself is not cleared, as only created entries are ever read.
`default_nettype none

module pair_link_table_store #(
  parameter int CAPACITY   = plts_pkg::CAPACITY_DEF,
  parameter int LINK_WIDTH = plts_pkg::LINK_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [plts_pkg::CNT_W-1:0]  cfg_wdata,
  plts_in_if.sink                          in_ch,
  plts_out_if.source                       out_ch
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int IW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (IW > plts_pkg::IDX_W) ? IW : plts_pkg::IDX_W;
  localparam int LW   = LINK_WIDTH;
  localparam int CW   = plts_pkg::CNT_W;
  localparam int XW   = plts_pkg::IDX_W;
  localparam int VW   = plts_pkg::VAL_W;

  plts_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              cap_r;
  logic [IW-1:0]              used_r, used_nxt;
  logic [plts_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [XW-1:0]              idx_r, idx_nxt;
  logic [LW-1:0]              sv_r, sv_nxt, tv_r, tv_nxt;
  logic [CW-1:0]              maxm_r, maxm_nxt;
  logic [IW-1:0]              cur_r, cur_nxt;
  logic [CW-1:0]              found_r, found_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  logic [IW-1:0]              pend_idx_r, pend_idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       o_status_r, o_status_nxt;
  logic [XW-1:0]              o_index_r, o_index_nxt;
  logic [VW-1:0]              o_src_r, o_src_nxt, o_tgt_r, o_tgt_nxt;
  logic [CW-1:0]              o_cnt_r, o_cnt_nxt;
  logic                       o_last_r, o_last_nxt;

  logic [2*LW-1:0]            mem [CAPACITY];
  logic [2*LW-1:0]            rd_data_r;
  logic [AW-1:0]              ra, wa;
  logic                       we;
  logic [2*LW-1:0]            wd;

  logic                       in_fire, out_free, emit;
  logic [LW-1:0]              ent_src, ent_tgt, ent_pat;
  logic [CMPW-1:0]            ent_idx;
  logic                       ent_live, ent_hit, idx_ok, full, scan_end, is_search;
  logic                       scan_stall;
  logic [CW-1:0]              found_inc;
  logic                       new_is_scan;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == plts_pkg::S_IDLE);

  assign ent_src   = rd_data_r[2*LW-1:LW];
  assign ent_tgt   = rd_data_r[LW-1:0];
  assign ent_idx   = (state_r == plts_pkg::S_SCAN) ? CMPW'(cur_r) : CMPW'(idx_r);
  assign ent_pat   = LW'(ent_idx);
  // a deleted slot holds its own index as source and zero as target
  assign ent_live  = !((ent_src == ent_pat) && (ent_tgt == '0));
  assign ent_hit   = ent_live && ((sv_r == '0) || (ent_src == sv_r))
                              && ((tv_r == '0) || (ent_tgt == tv_r));
  assign idx_ok    = (idx_r != '0) && (CMPW'(idx_r) <= CMPW'(used_r));
  assign full      = (CMPW'(used_r) >= CMPW'(cap_r)) || (CMPW'(used_r) >= CMPW'(CAPACITY));
  assign scan_end  = (cur_r == used_r);
  assign is_search = (op_r == plts_pkg::OP_SEARCH);
  assign found_inc = found_r + 1'b1;
  // a second match cannot be taken until the held one has gone out
  assign scan_stall = (state_r == plts_pkg::S_SCAN) && is_search && ent_hit
                      && pend_valid_r && !out_free;
  assign new_is_scan = (in_ch.operation == plts_pkg::OP_COUNT) ||
                       (in_ch.operation == plts_pkg::OP_SEARCH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plts_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            plts_pkg::OP_CREATE: state_nxt = plts_pkg::S_CREATE;
            plts_pkg::OP_READ,
            plts_pkg::OP_UPDATE,
            plts_pkg::OP_DELETE: state_nxt = plts_pkg::S_CHECK;
            plts_pkg::OP_COUNT:
              state_nxt = (used_r == '0) ? plts_pkg::S_FINISH : plts_pkg::S_SCAN;
            plts_pkg::OP_SEARCH: begin
              if (in_ch.max_matches == '0) state_nxt = plts_pkg::S_ERROR;
              else if (used_r == '0)       state_nxt = plts_pkg::S_FINISH;
              else                         state_nxt = plts_pkg::S_SCAN;
            end
            default: state_nxt = plts_pkg::S_ERROR;
          endcase
        end
      end
      plts_pkg::S_SCAN: begin
        if (!scan_stall) begin
          if ((is_search && ent_hit && (found_inc == maxm_r)) || scan_end) begin
            state_nxt = plts_pkg::S_FINISH;
          end
        end
      end
      plts_pkg::S_CREATE,
      plts_pkg::S_CHECK,
      plts_pkg::S_FINISH,
      plts_pkg::S_ERROR: begin
        if (out_free) state_nxt = plts_pkg::S_IDLE;
      end
      default: state_nxt = plts_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and result beats
  always_comb begin
    used_nxt       = used_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    sv_nxt         = sv_r;
    tv_nxt         = tv_r;
    maxm_nxt       = maxm_r;
    cur_nxt        = cur_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    ra             = '0;
    we             = 1'b0;
    wa             = AW'(idx_r - 1'b1);
    wd             = {sv_r, tv_r};
    emit           = 1'b0;
    o_status_nxt   = plts_pkg::ST_OK;
    o_index_nxt    = '0;
    o_src_nxt      = '0;
    o_tgt_nxt      = '0;
    o_cnt_nxt      = '0;
    o_last_nxt     = 1'b1;
    case (state_r)
      plts_pkg::S_IDLE: begin
        ra = new_is_scan ? '0 : AW'(in_ch.entry_index - 1'b1);
        if (in_fire) begin
          op_nxt         = in_ch.operation;
          idx_nxt        = in_ch.entry_index;
          sv_nxt         = LW'(in_ch.source_value);
          tv_nxt         = LW'(in_ch.target_value);
          maxm_nxt       = in_ch.max_matches;
          cur_nxt        = IW'(1);
          found_nxt      = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      plts_pkg::S_CREATE: begin
        if (out_free) begin
          emit = 1'b1;
          if (full) begin
            o_status_nxt = plts_pkg::ST_ERR;
          end else begin
            we          = 1'b1;
            wa          = AW'(used_r);
            used_nxt    = used_r + 1'b1;
            o_index_nxt = XW'(CMPW'(used_r) + 1'b1);
          end
        end
      end
      plts_pkg::S_CHECK: begin
        ra = AW'(idx_r - 1'b1);
        if (out_free) begin
          emit = 1'b1;
          if (!(idx_ok && ent_live)) begin
            o_status_nxt = plts_pkg::ST_ERR;
          end else begin
            case (op_r)
              plts_pkg::OP_READ: begin
                o_src_nxt = VW'(ent_src);
                o_tgt_nxt = VW'(ent_tgt);
              end
              plts_pkg::OP_UPDATE: we = 1'b1;
              plts_pkg::OP_DELETE: begin
                we = 1'b1;
                wd = {ent_pat, LW'(0)};
              end
              default: o_status_nxt = plts_pkg::ST_ERR;
            endcase
          end
        end
      end
      plts_pkg::S_SCAN: begin
        ra = scan_stall ? AW'(cur_r - 1'b1) : AW'(cur_r);
        if (!scan_stall) begin
          cur_nxt = cur_r + 1'b1;
          if (!is_search) begin
            if (ent_live) found_nxt = found_inc;
          end else if (ent_hit) begin
            // the held match is known not to be last once another turns up
            if (pend_valid_r) begin
              emit        = 1'b1;
              o_index_nxt = XW'(pend_idx_r);
              o_cnt_nxt   = found_r;
              o_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = cur_r;
            found_nxt      = found_inc;
          end
        end
      end
      plts_pkg::S_FINISH: begin
        if (out_free) begin
          emit = 1'b1;
          if (!is_search) begin
            o_cnt_nxt = found_r;
          end else if (pend_valid_r) begin
            o_index_nxt = XW'(pend_idx_r);
            o_cnt_nxt   = found_r;
          end
        end
      end
      plts_pkg::S_ERROR: begin
        if (out_free) begin
          emit         = 1'b1;
          o_status_nxt = plts_pkg::ST_ERR;
        end
      end
      default: ;
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plts_pkg::S_IDLE;
      cap_r        <= plts_pkg::CAP_RESET;
      used_r       <= '0;
      found_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      used_r       <= used_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    sv_r       <= sv_nxt;
    tv_r       <= tv_nxt;
    maxm_r     <= maxm_nxt;
    cur_r      <= cur_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (emit) begin
      o_status_r <= o_status_nxt;
      o_index_r  <= o_index_nxt;
      o_src_r    <= o_src_nxt;
      o_tgt_r    <= o_tgt_nxt;
      o_cnt_r    <= o_cnt_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  // pair memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.result_index = o_index_r;
  assign out_ch.source_out   = o_src_r;
  assign out_ch.target_out   = o_tgt_r;
  assign out_ch.match_count  = o_cnt_r;
  assign out_ch.last         = o_last_r;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(used_r) <= CMPW'(CAPACITY))
    else $error("used count beyond capacity");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (used_r != $past(used_r))) |-> (used_r == IW'($past(used_r) + 1'b1)))
    else $error("used count moved by other than one");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plts_pkg::S_SCAN) |-> ((cur_r != '0) && (cur_r <= used_r)))
    else $error("scan pointer outside used entries");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == plts_pkg::S_SCAN) && is_search) |-> (found_r < maxm_r))
    else $error("search went past max matches");

  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (found_r != '0))
    else $error("held match without a match count");
`endif

endmodule

`default_nettype wire

// File: tb/sv/pair_link_table_checker.sv
// Checker for the pair link table store: tracks the table, predicts every result beat.
// Depends on plts_pkg and the plts_in_if / plts_out_if channel interfaces.
`timescale 1ns / 1ps

module pair_link_table_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [plts_pkg::CNT_W-1:0]   cfg_wdata,
  plts_in_if                           req_ch,
  plts_out_if                          rsp_ch,
  output int unsigned                  fail_count,
  output int unsigned                  results_due,
  output int unsigned                  results_seen,
  output int unsigned                  entries_used
);

  localparam int XW  = plts_pkg::IDX_W;
  localparam int VW  = plts_pkg::VAL_W;
  localparam int CW  = plts_pkg::CNT_W;
  localparam int CAP = plts_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic          status;
    logic [XW-1:0] result_index;
    logic [VW-1:0] source_out;
    logic [VW-1:0] target_out;
    logic [CW-1:0] match_count;
    logic          last;
  } link_result_t;

  link_result_t  due_results[$];
  link_result_t  want;
  logic [VW-1:0] pair_source [1:CAP];
  logic [VW-1:0] pair_target [1:CAP];
  int unsigned   entries_made;
  logic [CW-1:0] usable_cap;

  // An entry holding (own index, 0) counts as deleted.
  function automatic bit entry_live(input int unsigned n);
    if (n == 0 || n > entries_made || n > CAP) return 1'b0;
    return !(pair_source[n] == n[VW-1:0] && pair_target[n] == '0);
  endfunction

  task apply_table_op(input logic [plts_pkg::OP_W-1:0] op,
                      input logic [XW-1:0]             idx,
                      input logic [VW-1:0]             src,
                      input logic [VW-1:0]             dst,
                      input logic [CW-1:0]             limit);
    link_result_t res;
    link_result_t hit;
    int unsigned  room;
    int unsigned  n;
    int unsigned  hits;
    res = '0;
    res.last = 1'b1;
    hit = '0;
    hits = 0;
    room = (32'(usable_cap) < CAP) ? 32'(usable_cap) : CAP;
    case (op)
      plts_pkg::OP_CREATE: begin
        if (entries_made >= room) begin
          res.status = plts_pkg::ST_ERR;
        end else begin
          entries_made++;
          pair_source[entries_made] = src;
          pair_target[entries_made] = dst;
          res.result_index = entries_made[XW-1:0];
        end
      end
      plts_pkg::OP_READ: begin
        if (entry_live(32'(idx))) begin
          res.source_out = pair_source[idx];
          res.target_out = pair_target[idx];
        end else begin
          res.status = plts_pkg::ST_ERR;
        end
      end
      plts_pkg::OP_UPDATE: begin
        if (entry_live(32'(idx))) begin
          pair_source[idx] = src;
          pair_target[idx] = dst;
        end else begin
          res.status = plts_pkg::ST_ERR;
        end
      end
      plts_pkg::OP_DELETE: begin
        if (entry_live(32'(idx))) begin
          pair_source[idx] = idx;
          pair_target[idx] = '0;
        end else begin
          res.status = plts_pkg::ST_ERR;
        end
      end
      plts_pkg::OP_COUNT: begin
        for (n = 1; n <= entries_made; n++)
          if (entry_live(n)) hits++;
        res.match_count = hits[CW-1:0];
      end
      plts_pkg::OP_SEARCH: begin
        if (limit == '0) begin
          res.status = plts_pkg::ST_ERR;
        end else begin
          // hold back each match until the next one shows it is not the last
          for (n = 1; n <= entries_made && hits < 32'(limit); n++) begin
            if (entry_live(n) && (src == '0 || pair_source[n] == src) &&
                (dst == '0 || pair_target[n] == dst)) begin
              if (hits != 0) due_results.push_back(hit);
              hits++;
              hit = '0;
              hit.result_index = n[XW-1:0];
              hit.match_count = hits[CW-1:0];
            end
          end
          if (hits != 0) begin
            hit.last = 1'b1;
            res = hit;
          end
        end
      end
      default: res.status = plts_pkg::ST_ERR;
    endcase
    due_results.push_back(res);
  endtask

  task check_field(input string field, input logic [XW-1:0] exp_val,
                   input logic [XW-1:0] got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      entries_made = 0;
      usable_cap = plts_pkg::CAP_RESET;
      due_results.delete();
    end else begin
      if (cfg_we) usable_cap = cfg_wdata;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        results_seen++;
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat with nothing outstanding, expected none, got index %0h",
                   $time, rsp_ch.result_index);
        end else begin
          want = due_results.pop_front();
          check_field("status",       XW'(want.status),      XW'(rsp_ch.status));
          check_field("result_index", want.result_index,     rsp_ch.result_index);
          check_field("source_out",   want.source_out,       rsp_ch.source_out);
          check_field("target_out",   want.target_out,       rsp_ch.target_out);
          check_field("match_count",  XW'(want.match_count), XW'(rsp_ch.match_count));
          check_field("last",         XW'(want.last),        XW'(rsp_ch.last));
        end
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        apply_table_op(req_ch.operation, req_ch.entry_index, req_ch.source_value,
                       req_ch.target_value, req_ch.max_matches);
    end
    results_due = 32'(due_results.size());
    entries_used = entries_made;
  end

endmodule

// File: tb/sv/pair_link_table_store_test.sv
// Top of the pair link table store testbench: clock, reset, request and result drivers.
// Depends on plts_pkg, the channel interfaces, the design and pair_link_table_checker.
`timescale 1ns / 1ps

module pair_link_table_store_test;

  localparam int XW = plts_pkg::IDX_W;
  localparam int VW = plts_pkg::VAL_W;
  localparam int CW = plts_pkg::CNT_W;
  localparam int OW = plts_pkg::OP_W;

  localparam logic [OW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OW-1:0] OP_RSVD7 = 3'd7;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 80;
  localparam int unsigned PHASE_ITEMS   = 145;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  plts_in_if  in_ch ();
  plts_out_if out_ch ();

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned results_seen;
  int unsigned entries_used;
  int unsigned requests_sent;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 79;
  bit          hold_req = 1'b0;

  pair_link_table_store DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pair_link_table_checker link_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_ch       (in_ch),
    .rsp_ch       (out_ch),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen),
    .entries_used (entries_used)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request beat, with random idle cycles first; returns at the accepting edge.
  task send_request(input logic [OW-1:0] op,
                    input logic [XW-1:0] idx,
                    input logic [VW-1:0] src,
                    input logic [VW-1:0] dst,
                    input logic [CW-1:0] limit);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.entry_index  <= idx;
    in_ch.source_value <= src;
    in_ch.target_value <= dst;
    in_ch.max_matches  <= limit;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    requests_sent++;
  endtask

  task drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task write_capacity(input logic [CW-1:0] cap);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a small pool so searches find matches, with edges and full-width noise.
  function automatic logic [VW-1:0] link_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return VW'($urandom_range(6, 1));
    if (pick < 70) return '0;
    if (pick < 80) return '1;
    return VW'($urandom);
  endfunction

  task send_random_request();
    logic [OW-1:0] op;
    logic [XW-1:0] idx;
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [CW-1:0] limit;
    int unsigned   pick;
    idx   = XW'($urandom);
    src   = VW'($urandom);
    dst   = VW'($urandom);
    limit = CW'($urandom);
    pick  = $urandom_range(99);
    if (pick < 22)      op = plts_pkg::OP_CREATE;
    else if (pick < 38) op = plts_pkg::OP_READ;
    else if (pick < 50) op = plts_pkg::OP_UPDATE;
    else if (pick < 60) op = plts_pkg::OP_DELETE;
    else if (pick < 68) op = plts_pkg::OP_COUNT;
    else if (pick < 96) op = plts_pkg::OP_SEARCH;
    else                op = pick[0] ? OP_RSVD7 : OP_RSVD6;
    if ($urandom_range(99) < 85) idx = XW'($urandom_range(entries_used + 1, 1));
    case (op)
      plts_pkg::OP_CREATE, plts_pkg::OP_UPDATE: begin
        src = link_value();
        dst = link_value();
      end
      plts_pkg::OP_SEARCH: begin
        src = ($urandom_range(99) < 40) ? '0 : link_value();
        dst = ($urandom_range(99) < 40) ? '0 : link_value();
        pick = $urandom_range(99);
        if (pick < 70)      limit = CW'($urandom_range(8, 1));
        else if (pick < 85) limit = CW'(plts_pkg::CAPACITY_DEF);
        else if (pick < 95) limit = CW'($urandom);
        else                limit = '0;
      end
      default: ;
    endcase
    // now and then rewrite an entry into the deleted pattern
    if (op == plts_pkg::OP_UPDATE && $urandom_range(19) == 0) begin
      src = idx;
      dst = '0;
    end
    send_request(op, idx, src, dst, limit);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned held;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = plts_pkg::OP_CREATE;
    in_ch.entry_index  = '0;
    in_ch.source_value = '0;
    in_ch.target_value = '0;
    in_ch.max_matches  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table at the reset capacity
    send_request(plts_pkg::OP_COUNT,  16'h0000, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_SEARCH, 16'h0000, 16'h0000, 16'h0000, 7'd5);
    send_request(plts_pkg::OP_SEARCH, 16'h0000, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_READ,   16'h0000, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_READ,   16'h0001, 16'h0000, 16'h0000, 7'd0);
    // single slot: created in the deleted pattern, then the table is full
    write_capacity(7'd1);
    send_request(plts_pkg::OP_CREATE, 16'h0000, 16'h0001, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_CREATE, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0);
    send_request(plts_pkg::OP_READ,   16'h0001, 16'h0000, 16'h0000, 7'd0);
    write_capacity(7'd0);
    send_request(plts_pkg::OP_CREATE, 16'hFFFF, 16'h1234, 16'h5678, 7'h7F);
    write_capacity(7'd64);
    send_request(plts_pkg::OP_CREATE, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0);
    send_request(plts_pkg::OP_CREATE, 16'h0000, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_CREATE, 16'h0000, 16'h1234, 16'hFFFF, 7'd0);
    send_request(plts_pkg::OP_READ,   16'h0002, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_READ,   16'hFFFF, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_UPDATE, 16'h0003, 16'h1234, 16'hABCD, 7'd0);
    send_request(plts_pkg::OP_UPDATE, 16'h0001, 16'h5555, 16'h5555, 7'd0);
    send_request(plts_pkg::OP_SEARCH, 16'h0000, 16'h1234, 16'h0000, 7'd64);
    send_request(plts_pkg::OP_SEARCH, 16'h0000, 16'h0000, 16'hFFFF, 7'd1);
    send_request(plts_pkg::OP_DELETE, 16'h0002, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_DELETE, 16'h0002, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_UPDATE, 16'h0004, 16'h0004, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_COUNT,  16'h0000, 16'h0000, 16'h0000, 7'd0);
    send_request(OP_RSVD6,            16'h0003, 16'h0000, 16'h0000, 7'd0);
    send_request(OP_RSVD7,            16'h0003, 16'h0000, 16'h0000, 7'd0);
    send_request(plts_pkg::OP_SEARCH, 16'h0000, 16'h0000, 16'h0000, 7'h7F);

    // capacity above the table size: limited to 64
    write_capacity(7'h7F);
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 40) hold_req = 1'b1;
      send_random_request();
    end

    // capacity below the fill level: existing entries stay valid, creates fail
    write_capacity(7'd20);
    tx_idle_pct = 79;
    rx_idle_pct = 10;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 75) drain_results();
      send_random_request();
    end

    write_capacity(7'd64);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (n = 0; n < PHASE_ITEMS; n++) send_random_request();

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d requests giving %0d result beats; capacities 1, 0, 64, 127 and 20,",
             requests_sent, results_seen);
    $display("table filled to %0d entries, both idle patterns and a long result hold-off.",
             entries_used);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/plts_pkg.sv
design/plts_in_if.sv
design/plts_out_if.sv
design/pair_link_table_store.sv
tb/sv/pair_link_table_checker.sv
tb/sv/pair_link_table_store_test.sv
